FILE: sv/rmft_pkg.sv
package rmft_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 128;
    localparam int IP_W     = 10;
    localparam int STATUS_W = 3;
    localparam int IDX_W    = 7;
    localparam int COUNT_W  = 32;
    localparam int SW_W     = 4;

    localparam logic [2:0]  OWN_SWITCH_RESET = 3'd1;
    localparam logic [9:0]  IP_LIMIT_RESET   = 10'd1000;

    localparam logic [0:0]  REG_OWN_SWITCH = 1'b0;
    localparam logic [0:0]  REG_IP_LIMIT   = 1'b1;

    localparam logic [0:0]  OP_LOOKUP = 1'b0;
    localparam logic [0:0]  OP_ADD    = 1'b1;

    localparam logic [0:0]  ACT_FORWARD = 1'b0;
    localparam logic [1:0]  PORT_LOWER  = 2'd1;
    localparam logic [1:0]  PORT_UPPER  = 2'd2;
    localparam logic [1:0]  PORT_LOCAL  = 2'd3;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_BAD_SRC  = 3'd1,
        ST_BAD_DST  = 3'd2,
        ST_FULL     = 3'd3,
        ST_COUNTED  = 3'd4,
        ST_RELAYED  = 3'd5,
        ST_MISS     = 3'd6,
        ST_FILTERED = 3'd7
    } t_status;

    // Classified request handed from the front end to the table engine.
    typedef struct packed {
        logic            is_add;
        logic            check_src;
        logic [IP_W-1:0] src_ip;
        logic [IP_W-1:0] dest_ip;
        logic [IP_W-1:0] src_low;
        logic [IP_W-1:0] src_high;
        logic [IP_W-1:0] dst_low;
        logic [IP_W-1:0] dst_high;
        logic            action;
        logic [1:0]      port;
        logic [7:0]      init_count;
        t_status         bad_status;
        logic            bad;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [IDX_W-1:0]     rule_index;
        logic [COUNT_W-1:0]   packet_count;
        logic [1:0]           relay_port;
        logic [SW_W-1:0]      relay_switch;
    } t_res;

endpackage

FILE: sv/rmft_front.sv
module rmft_front
    import rmft_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  logic            i_op,
    input  logic            i_from_neighbour,
    input  logic [IP_W-1:0] i_src_ip,
    input  logic [IP_W-1:0] i_dest_ip,
    input  logic [IP_W-1:0] i_rule_src_low,
    input  logic [IP_W-1:0] i_rule_src_high,
    input  logic [IP_W-1:0] i_rule_dst_low,
    input  logic [IP_W-1:0] i_rule_dst_high,
    input  logic            i_rule_action,
    input  logic [1:0]      i_rule_port,
    input  logic [7:0]      i_initial_count,
    input  logic [IP_W-1:0] i_ip_limit,
    output logic            o_req_valid,
    output t_req            o_req,
    input  logic            i_req_take
);

    // Two-entry queue between classification and the table engine.
    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_req       n_req;
    logic       w_push;

    always_comb begin
        n_req            = '0;
        n_req.is_add     = (i_op == OP_ADD);
        n_req.check_src  = !i_from_neighbour;
        n_req.src_ip     = i_src_ip;
        n_req.dest_ip    = i_dest_ip;
        n_req.src_low    = i_rule_src_low;
        n_req.src_high   = i_rule_src_high;
        n_req.dst_low    = i_rule_dst_low;
        n_req.dst_high   = i_rule_dst_high;
        n_req.action     = i_rule_action;
        n_req.port       = i_rule_port;
        n_req.init_count = i_initial_count;
        n_req.bad_status = ST_ADDED;
        if (i_rule_src_low > i_rule_src_high || i_rule_src_high > i_ip_limit) begin
            n_req.bad        = 1'b1;
            n_req.bad_status = ST_BAD_SRC;
        end else if (i_rule_dst_low > i_rule_dst_high || i_rule_dst_high > i_ip_limit) begin
            n_req.bad        = 1'b1;
            n_req.bad_status = ST_BAD_DST;
        end
    end

    assign o_full      = (r_cnt == 2'd2);
    assign w_push      = i_push && !o_full;
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= n_req;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_req_take) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_req_take};
        end
    end

endmodule

FILE: sv/rmft_engine.sv
module rmft_engine
    import rmft_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  t_req       i_req,
    output logic       o_req_take,
    input  logic [2:0] i_own_switch,
    input  logic       i_pop,
    output logic       o_empty,
    output t_res       o_res
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SRC   = 6'b000010,
        S_SCAN  = 6'b000100,
        S_CHECK = 6'b001000,
        S_WRITE = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    logic [IP_W-1:0]    r_slo_mem [TABLE_DEPTH];
    logic [IP_W-1:0]    r_shi_mem [TABLE_DEPTH];
    logic [IP_W-1:0]    r_dlo_mem [TABLE_DEPTH];
    logic [IP_W-1:0]    r_dhi_mem [TABLE_DEPTH];
    logic               r_act_mem [TABLE_DEPTH];
    logic [1:0]         r_port_mem [TABLE_DEPTH];
    logic [COUNT_W-1:0] r_cnt_mem [TABLE_DEPTH];

    t_state             r_state;
    t_req               r_req;
    logic [CW-1:0]      r_used;
    logic [CW-1:0]      r_idx;
    logic [AW-1:0]      r_rd_addr;
    logic [IP_W-1:0]    r_rd_slo, r_rd_shi, r_rd_dlo, r_rd_dhi;
    logic               r_rd_act;
    logic [1:0]         r_rd_port;
    logic [COUNT_W-1:0] r_rd_cnt;
    logic               r_res_valid;
    t_res               r_res;
    t_res               r_acc;

    logic               w_hit;
    logic [COUNT_W-1:0] w_inc;
    logic [SW_W-1:0]    w_sw;
    logic               w_load;

    assign o_empty    = !r_res_valid;
    assign o_req_take = (r_state == S_IDLE) && i_req_valid;
    assign o_res      = r_res;
    assign w_load     = (r_state == S_OUT) && (!r_res_valid || i_pop);

    assign w_hit = (r_rd_dlo <= r_req.dest_ip) && (r_req.dest_ip <= r_rd_dhi);
    assign w_inc = (r_rd_cnt == '1) ? r_rd_cnt : r_rd_cnt + 1'b1;
    always_comb begin
        if (r_rd_port == PORT_UPPER) begin
            w_sw = {1'b0, i_own_switch} + 1'b1;
        end else if (i_own_switch == 3'd0) begin
            w_sw = '0;
        end else begin
            w_sw = {1'b0, i_own_switch - 3'd1};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_slo  <= r_slo_mem[r_rd_addr];
        r_rd_shi  <= r_shi_mem[r_rd_addr];
        r_rd_dlo  <= r_dlo_mem[r_rd_addr];
        r_rd_dhi  <= r_dhi_mem[r_rd_addr];
        r_rd_act  <= r_act_mem[r_rd_addr];
        r_rd_port <= r_port_mem[r_rd_addr];
        r_rd_cnt  <= r_cnt_mem[r_rd_addr];
        if (r_state == S_WRITE) begin
            r_slo_mem[r_used[AW-1:0]]  <= r_req.src_low;
            r_shi_mem[r_used[AW-1:0]]  <= r_req.src_high;
            r_dlo_mem[r_used[AW-1:0]]  <= r_req.dst_low;
            r_dhi_mem[r_used[AW-1:0]]  <= r_req.dst_high;
            r_act_mem[r_used[AW-1:0]]  <= r_req.action;
            r_port_mem[r_used[AW-1:0]] <= r_req.port;
            r_cnt_mem[r_used[AW-1:0]]  <= {{(COUNT_W-8){1'b0}}, r_req.init_count};
        end
        if (r_state == S_CHECK && w_hit) begin
            r_cnt_mem[r_idx[AW-1:0]] <= w_inc;
        end

        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_idx       <= '0;
            r_rd_addr   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_res       <= r_acc;
                r_res_valid <= 1'b1;
            end else if (i_pop) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req              <= i_req;
                        r_idx              <= '0;
                        r_rd_addr          <= '0;
                        r_acc.rule_index   <= '0;
                        r_acc.packet_count <= '0;
                        r_acc.relay_port   <= '0;
                        r_acc.relay_switch <= '0;
                        if (i_req.is_add) begin
                            if (i_req.bad) begin
                                r_acc.status <= i_req.bad_status;
                                r_state      <= S_OUT;
                            end else if (r_used == CW'(TABLE_DEPTH)) begin
                                r_acc.status <= ST_FULL;
                                r_state      <= S_OUT;
                            end else begin
                                r_acc.status <= ST_ADDED;
                                r_state      <= S_WRITE;
                            end
                        end else if (i_req.check_src) begin
                            r_state <= S_SRC;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SRC: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_req.check_src
                        && (r_req.src_ip < r_rd_slo || r_req.src_ip > r_rd_shi)) begin
                        r_acc.status <= ST_FILTERED;
                        r_state      <= S_OUT;
                    end else if (r_idx >= r_used) begin
                        r_acc.status <= ST_MISS;
                        r_state      <= S_OUT;
                    end else begin
                        r_req.check_src <= 1'b0;
                        r_state         <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_hit) begin
                        r_acc.rule_index   <= IDX_W'(r_idx);
                        r_acc.packet_count <= w_inc;
                        if (r_rd_act == ACT_FORWARD && r_rd_port != PORT_LOCAL) begin
                            r_acc.status       <= ST_RELAYED;
                            r_acc.relay_port   <= r_rd_port;
                            r_acc.relay_switch <= w_sw;
                        end else begin
                            r_acc.status <= ST_COUNTED;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_idx     <= r_idx + 1'b1;
                        r_rd_addr <= AW'(r_idx + 1'b1);
                        r_state   <= S_SCAN;
                    end
                end
                S_WRITE: begin
                    r_acc.rule_index   <= IDX_W'(r_used);
                    r_acc.packet_count <= {{(COUNT_W-8){1'b0}}, r_req.init_count};
                    r_used             <= r_used + 1'b1;
                    r_state            <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/range_match_forwarding_table_top.sv
// A stored add passes S_IDLE, S_WRITE and S_OUT, and a rejected add goes from S_IDLE to S_OUT.
// A local lookup passes S_SRC, then S_SCAN and S_CHECK for each rule checked, then S_OUT (a
// lookup from a neighbour skips S_SRC), since each rule needs a memory read and a compare.
// Requests are handled one at a time, and a two-entry request queue and a result register
// let both sides stall.
// Reset (synchronous, active low) clears the rule count, queues and registers;
// rule memories are not cleared and hold no meaning until written.
module range_match_forwarding_table_top
    import rmft_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic                i_op,
    input  logic                i_from_neighbour,
    input  logic [IP_W-1:0]     i_src_ip,
    input  logic [IP_W-1:0]     i_dest_ip,
    input  logic [IP_W-1:0]     i_rule_src_low,
    input  logic [IP_W-1:0]     i_rule_src_high,
    input  logic [IP_W-1:0]     i_rule_dst_low,
    input  logic [IP_W-1:0]     i_rule_dst_high,
    input  logic                i_rule_action,
    input  logic [1:0]          i_rule_port,
    input  logic [7:0]          i_initial_count,
    output logic                o_empty,
    input  logic                i_pop,
    output logic [STATUS_W-1:0] o_status,
    output logic [IDX_W-1:0]    o_rule_index,
    output logic [COUNT_W-1:0]  o_packet_count,
    output logic [1:0]          o_relay_port,
    output logic [SW_W-1:0]     o_relay_switch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [2:0]      r_own_switch;
    logic [IP_W-1:0] r_ip_limit;
    logic            w_req_valid, w_req_take;
    t_req            w_req;
    t_res            w_res;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_switch <= OWN_SWITCH_RESET;
            r_ip_limit   <= IP_LIMIT_RESET;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
            if (paddr[2] == REG_OWN_SWITCH) begin
                r_own_switch <= pwdata[2:0];
            end else begin
                r_ip_limit <= pwdata[IP_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'd0) begin
            if (paddr[2] == REG_OWN_SWITCH) begin
                prdata = {29'd0, r_own_switch};
            end else if (paddr[2] == REG_IP_LIMIT) begin
                prdata = {22'd0, r_ip_limit};
            end
        end
    end

    rmft_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_op             (i_op),
        .i_from_neighbour (i_from_neighbour),
        .i_src_ip         (i_src_ip),
        .i_dest_ip        (i_dest_ip),
        .i_rule_src_low   (i_rule_src_low),
        .i_rule_src_high  (i_rule_src_high),
        .i_rule_dst_low   (i_rule_dst_low),
        .i_rule_dst_high  (i_rule_dst_high),
        .i_rule_action    (i_rule_action),
        .i_rule_port      (i_rule_port),
        .i_initial_count  (i_initial_count),
        .i_ip_limit       (r_ip_limit),
        .o_req_valid      (w_req_valid),
        .o_req            (w_req),
        .i_req_take       (w_req_take)
    );

    rmft_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (w_req_valid),
        .i_req        (w_req),
        .o_req_take   (w_req_take),
        .i_own_switch (r_own_switch),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_res        (w_res)
    );

    assign o_status       = w_res.status;
    assign o_rule_index   = w_res.rule_index;
    assign o_packet_count = w_res.packet_count;
    assign o_relay_port   = w_res.relay_port;
    assign o_relay_switch = w_res.relay_switch;

endmodule

FILE: tb/sv/tb_range_match_forwarding_table_top.sv
module tb_range_match_forwarding_table_top;
    import rmft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [0:0] ACT_DROP  = 1'b1;
    localparam logic [1:0] PORT_ZERO = 2'd0;
    localparam int DEPTH = DEFAULT_TABLE_DEPTH;
    localparam int RANDOM_ITEMS = 1280;
    localparam int NUM_PHASES = 6;

    typedef struct packed {
        logic            op;
        logic            nb;
        logic [IP_W-1:0] src_ip;
        logic [IP_W-1:0] dest_ip;
        logic [IP_W-1:0] slo;
        logic [IP_W-1:0] shi;
        logic [IP_W-1:0] dlo;
        logic [IP_W-1:0] dhi;
        logic            act;
        logic [1:0]      port;
        logic [7:0]      init;
    } t_request;

    localparam int REQ_W = $bits(t_request);

    typedef struct packed {
        t_request req;
        logic     typed;
        t_res     want;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_push = 1'b0;
    logic                o_full;
    logic                i_op = 1'b0;
    logic                i_from_neighbour = 1'b0;
    logic [IP_W-1:0]     i_src_ip = '0;
    logic [IP_W-1:0]     i_dest_ip = '0;
    logic [IP_W-1:0]     i_rule_src_low = '0;
    logic [IP_W-1:0]     i_rule_src_high = '0;
    logic [IP_W-1:0]     i_rule_dst_low = '0;
    logic [IP_W-1:0]     i_rule_dst_high = '0;
    logic                i_rule_action = 1'b0;
    logic [1:0]          i_rule_port = '0;
    logic [7:0]          i_initial_count = '0;
    logic                o_empty;
    logic                i_pop = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [IDX_W-1:0]    o_rule_index;
    logic [COUNT_W-1:0]  o_packet_count;
    logic [1:0]          o_relay_port;
    logic [SW_W-1:0]     o_relay_switch;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    range_match_forwarding_table_top dut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow copy of the rule table and registers.
    logic [IP_W-1:0]    tbl_src_lo [DEPTH];
    logic [IP_W-1:0]    tbl_src_hi [DEPTH];
    logic [IP_W-1:0]    tbl_dst_lo [DEPTH];
    logic [IP_W-1:0]    tbl_dst_hi [DEPTH];
    logic               tbl_act [DEPTH];
    logic [1:0]         tbl_port [DEPTH];
    logic [COUNT_W-1:0] tbl_count [DEPTH];
    int                 rules_stored = 0;
    logic [2:0]         own_switch = OWN_SWITCH_RESET;
    logic [IP_W-1:0]    ip_limit = IP_LIMIT_RESET;

    t_res pending_results[$];
    int   errors = 0;
    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;

    t_row directed[18] = '{
        '{'{OP_LOOKUP, 1'b1, 10'd0, 10'd5, 10'd0, 10'd0, 10'd0, 10'd0, ACT_FORWARD, PORT_ZERO,
            8'd0}, 1'b1, '{ST_MISS, 7'd0, 32'd0, 2'd0, 4'd0}},
        '{'{OP_ADD, 1'b0, 10'd0, 10'd0, 10'd0, 10'd1000, 10'd0, 10'd9, ACT_FORWARD, PORT_UPPER,
            8'd255}, 1'b1, '{ST_ADDED, 7'd0, 32'd255, 2'd0, 4'd0}},
        '{'{OP_ADD, 1'b0, 10'd0, 10'd0, 10'd5, 10'd4, 10'd0, 10'd9, ACT_FORWARD, PORT_UPPER,
            8'd1}, 1'b1, '{ST_BAD_SRC, 7'd0, 32'd0, 2'd0, 4'd0}},
        '{'{OP_ADD, 1'b0, 10'd0, 10'd0, 10'd0, 10'd1001, 10'd0, 10'd9, ACT_FORWARD, PORT_UPPER,
            8'd1}, 1'b1, '{ST_BAD_SRC, 7'd0, 32'd0, 2'd0, 4'd0}},
        '{'{OP_ADD, 1'b0, 10'd0, 10'd0, 10'd0, 10'd10, 10'd9, 10'd3, ACT_FORWARD, PORT_UPPER,
            8'd1}, 1'b1, '{ST_BAD_DST, 7'd0, 32'd0, 2'd0, 4'd0}},
        '{'{OP_ADD, 1'b0, 10'd0, 10'd0, 10'd0, 10'd10, 10'd0, 10'd1023, ACT_FORWARD, PORT_UPPER,
            8'd1}, 1'b1, '{ST_BAD_DST, 7'd0, 32'd0, 2'd0, 4'd0}},
        '{'{OP_ADD, 1'b0, 10'd0, 10'd0, 10'd1023, 10'd1022, 10'd1023, 10'd0, ACT_DROP,
            PORT_LOCAL, 8'd1}, 1'b1, '{ST_BAD_SRC, 7'd0, 32'd0, 2'd0, 4'd0}},
        '{'{OP_ADD, 1'b0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd10, 10'd500, ACT_DROP, PORT_LOWER,
            8'd0}, 1'b1, '{ST_ADDED, 7'd1, 32'd0, 2'd0, 4'd0}},
        '{'{OP_ADD, 1'b0, 10'd0, 10'd0, 10'd0, 10'd1000, 10'd1000, 10'd1000, ACT_FORWARD,
            PORT_ZERO, 8'd7}, 1'b1, '{ST_ADDED, 7'd2, 32'd7, 2'd0, 4'd0}},
        '{'{OP_ADD, 1'b0, 10'd0, 10'd0, 10'd1000, 10'd1000, 10'd501, 10'd999, ACT_FORWARD,
            PORT_LOCAL, 8'd128}, 1'b1, '{ST_ADDED, 7'd3, 32'd128, 2'd0, 4'd0}},
        '{'{OP_LOOKUP, 1'b0, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, ACT_FORWARD,
            PORT_ZERO, 8'd0}, 1'b1, '{ST_FILTERED, 7'd0, 32'd0, 2'd0, 4'd0}},
        '{'{OP_LOOKUP, 1'b0, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1023, ACT_DROP,
            PORT_LOCAL, 8'd255}, 1'b0, '0},
        '{'{OP_LOOKUP, 1'b0, 10'd1000, 10'd9, 10'd0, 10'd0, 10'd0, 10'd0, ACT_FORWARD,
            PORT_ZERO, 8'd0}, 1'b0, '0},
        '{'{OP_LOOKUP, 1'b1, 10'd1023, 10'd10, 10'd0, 10'd0, 10'd0, 10'd0, ACT_FORWARD,
            PORT_ZERO, 8'd0}, 1'b0, '0},
        '{'{OP_LOOKUP, 1'b1, 10'd512, 10'd1000, 10'd0, 10'd0, 10'd0, 10'd0, ACT_FORWARD,
            PORT_ZERO, 8'd0}, 1'b0, '0},
        '{'{OP_LOOKUP, 1'b1, 10'd0, 10'd700, 10'd0, 10'd0, 10'd0, 10'd0, ACT_FORWARD,
            PORT_ZERO, 8'd0}, 1'b0, '0},
        '{'{OP_LOOKUP, 1'b1, 10'd0, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd0, ACT_FORWARD,
            PORT_ZERO, 8'd0}, 1'b1, '{ST_MISS, 7'd0, 32'd0, 2'd0, 4'd0}},
        '{'{OP_ADD, 1'b1, 10'd0, 10'd0, 10'd1000, 10'd1000, 10'd1000, 10'd1000, ACT_FORWARD,
            PORT_UPPER, 8'd0}, 1'b1, '{ST_ADDED, 7'd4, 32'd0, 2'd0, 4'd0}}
    };

    // Per phase: own switch, IP limit, sender idle percent, receiver stall percent.
    int phase_cfg[NUM_PHASES][4] = '{
        '{1, 1000, 0, 0},
        '{0, 1023, 47, 0},
        '{7, 0, 0, 47},
        '{3, 500, 37, 37},
        '{5, 1023, 0, 0},
        '{7, 1023, 47, 47}
    };

    function automatic t_res forward_table_step(t_request r);
        t_res res;
        res = '0;
        if (r.op == OP_ADD) begin
            if (r.slo > r.shi || r.shi > ip_limit) begin
                res.status = ST_BAD_SRC;
            end else if (r.dlo > r.dhi || r.dhi > ip_limit) begin
                res.status = ST_BAD_DST;
            end else if (rules_stored >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                tbl_src_lo[rules_stored] = r.slo;
                tbl_src_hi[rules_stored] = r.shi;
                tbl_dst_lo[rules_stored] = r.dlo;
                tbl_dst_hi[rules_stored] = r.dhi;
                tbl_act[rules_stored] = r.act;
                tbl_port[rules_stored] = r.port;
                tbl_count[rules_stored] = COUNT_W'(r.init);
                res.status = ST_ADDED;
                res.rule_index = IDX_W'(rules_stored);
                res.packet_count = COUNT_W'(r.init);
                rules_stored++;
            end
            return res;
        end
        if (!r.nb && (r.src_ip < tbl_src_lo[0] || r.src_ip > tbl_src_hi[0])) begin
            res.status = ST_FILTERED;
            return res;
        end
        for (int i = 0; i < rules_stored; i++) begin
            if (tbl_dst_lo[i] <= r.dest_ip && r.dest_ip <= tbl_dst_hi[i]) begin
                if (tbl_count[i] != '1) begin
                    tbl_count[i] = tbl_count[i] + 1;
                end
                res.rule_index = IDX_W'(i);
                res.packet_count = tbl_count[i];
                if (tbl_act[i] == ACT_FORWARD && tbl_port[i] != PORT_LOCAL) begin
                    res.status = ST_RELAYED;
                    res.relay_port = tbl_port[i];
                    if (tbl_port[i] == PORT_UPPER) begin
                        res.relay_switch = SW_W'(own_switch) + 1'b1;
                    end else begin
                        res.relay_switch = (own_switch == 0) ? '0 : SW_W'(own_switch) - 1'b1;
                    end
                end else begin
                    res.status = ST_COUNTED;
                end
                return res;
            end
        end
        res.status = ST_MISS;
        return res;
    endfunction

    task automatic report(string field, longint unsigned got, longint unsigned want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $time);
        errors++;
    endtask

    task automatic send_request(t_request r, logic typed, t_res want);
        t_res predicted;
        if ($urandom_range(99) < tx_idle_pct) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_op <= r.op;
        i_from_neighbour <= r.nb;
        i_src_ip <= r.src_ip;
        i_dest_ip <= r.dest_ip;
        i_rule_src_low <= r.slo;
        i_rule_src_high <= r.shi;
        i_rule_dst_low <= r.dlo;
        i_rule_dst_high <= r.dhi;
        i_rule_action <= r.act;
        i_rule_port <= r.port;
        i_initial_count <= r.init;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        predicted = forward_table_step(r);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
    endtask

    task automatic write_register(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata != value) begin
            report("register readback", prdata, value);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_pop <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_results.size() == 0) begin
                $display("unexpected result with status %0d at %0t", o_status, $time);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_status != want.status) report("status", o_status, want.status);
                if (o_rule_index != want.rule_index) begin
                    report("rule_index", o_rule_index, want.rule_index);
                end
                if (o_packet_count != want.packet_count) begin
                    report("packet_count", o_packet_count, want.packet_count);
                end
                if (o_relay_port != want.relay_port) begin
                    report("relay_port", o_relay_port, want.relay_port);
                end
                if (o_relay_switch != want.relay_switch) begin
                    report("relay_switch", o_relay_switch, want.relay_switch);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        t_request r;
        int       per_phase;
        int       pick;
        int       lim;
        per_phase = RANDOM_ITEMS / NUM_PHASES;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_request(directed[k].req, directed[k].typed, directed[k].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            i_push <= 1'b0;
            wait (pending_results.size() == 0);
            repeat (2 * DEPTH + 10) @(posedge i_clk);
            own_switch = 3'(phase_cfg[ph][0]);
            ip_limit = IP_W'(phase_cfg[ph][1]);
            write_register(3'(4 * REG_OWN_SWITCH), 32'(own_switch));
            write_register(3'(4 * REG_IP_LIMIT), 32'(ip_limit));
            tx_idle_pct = phase_cfg[ph][2];
            rx_stall_pct = phase_cfg[ph][3];
            lim = ip_limit;
            for (int n = 0; n < per_phase; n++) begin
                if (ph == 4 && n == per_phase / 2) begin
                    i_push <= 1'b0;
                    wait (pending_results.size() == 0);
                    @(posedge i_clk);
                end
                r = REQ_W'({$urandom, $urandom, $urandom});
                if ($urandom_range(99) < 30) begin
                    r.op = OP_ADD;
                    if ($urandom_range(99) < 85) begin
                        r.slo = IP_W'($urandom_range(lim));
                        r.shi = IP_W'($urandom_range(lim, r.slo));
                        r.dlo = IP_W'($urandom_range(lim));
                        if ($urandom_range(1)) begin
                            r.dhi = IP_W'($urandom_range(lim, r.dlo));
                        end else begin
                            r.dhi = IP_W'((r.dlo + $urandom_range(20) > lim) ? lim
                                          : r.dlo + $urandom_range(20));
                        end
                    end
                end else begin
                    r.op = OP_LOOKUP;
                    if (rules_stored == 0) begin
                        r.nb = 1'b1;
                    end
                    if (!r.nb && rules_stored > 0 && $urandom_range(99) < 80) begin
                        r.src_ip = IP_W'($urandom_range(tbl_src_hi[0], tbl_src_lo[0]));
                    end
                    if (rules_stored > 0 && $urandom_range(99) < 70) begin
                        pick = $urandom_range(rules_stored - 1);
                        r.dest_ip = IP_W'($urandom_range(tbl_dst_hi[pick], tbl_dst_lo[pick]));
                    end
                end
                send_request(r, 1'b0, '0);
            end
        end
        i_push <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (2 * DEPTH + 20) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
